// File: hdl/multi_channel_led_blinker_defines.svh
// ----------------------------------------------------------------------------
// Multi-channel LED blinker assertion macros
// Shared concurrent check forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_LED_BLINKER_DEFINES_SVH
`define MULTI_CHANNEL_LED_BLINKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MCLB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCLB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mclb_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel LED blinker package
// Shared codes, reload constants and the command word passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package mclb_pkg;

   localparam int CNT_W    = 16;
   localparam int LED_W    = 3;
   localparam int CH_W     = 2;
   localparam int CH_EXT_W = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W   = 1;
   localparam int QCNT_W   = 2;

   localparam logic [CNT_W-1:0]    RELOAD_RESET = 16'd100;
   localparam logic [CNT_W-1:0]    RELOAD_ON    = 16'd10;
   localparam logic [CNT_W-1:0]    RELOAD_OFF   = 16'd500;
   localparam logic [CH_EXT_W-1:0] PATTERN_CH   = 5'd3;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_ON    = 2'd1,
      ACT_OFF   = 2'd2,
      ACT_BLINK = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_SET  = 2'd1,
      CMD_SKIP = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [CH_W-1:0]  channel;
      action_type       action;
      logic [CNT_W-1:0] on_period;
      logic [CNT_W-1:0] off_period;
      logic             paused;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic idle;
      logic load;
   } eng_status_type;

endpackage

`default_nettype wire

// File: hdl/multi_channel_led_blinker.sv
// ----------------------------------------------------------------------------
// Multi-channel LED blinker
// Countdown-driven LED controller with one pattern trigger channel.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with the req_ fields; the word is taken on
//   the rising edge where start is high and busy is low. req_mode low is a
//   one millisecond tick, high sets the style of req_channel.
//   Result channel: rsp_valid strobes for one cycle per word with the LED
//   levels after that word and the pattern_show pulse. The receiver cannot
//   stall, so no hold-off exists on this side.
//   Throughput: a tick walks every channel in the engine (one channel
//   per cycle through a single update path) and stops early when a paused
//   walk halts; a set, or a dropped set, ends at its first walk step. Words
//   back up in a two-entry queue; busy rises only while that queue is full.
//   Response: the strobe is raised in the cycle after the engine's last
//   walk step; queued words wait behind earlier ones.
//   Reset: synchronous; every countdown and period returns to 100, every
//   channel to not controlled, all LEDs off and the queue empties.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_channel_led_blinker_defines.svh"

module multi_channel_led_blinker
   import mclb_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_mode,
   input  wire logic [CH_W-1:0]  req_channel,
   input  wire logic [1:0]       req_action,
   input  wire logic [CNT_W-1:0] req_on_period,
   input  wire logic [CNT_W-1:0] req_off_period,
   input  wire logic             req_paused,
   output logic                  rsp_valid,
   output logic [LED_W-1:0]      rsp_led_levels,
   output logic                  rsp_pattern_show
);

   // queue handshake between front end and engine
   logic             q_push;
   logic             q_pop;
   cmd_type          q_wr_word;
   cmd_type          q_rd_word;
   queue_status_type q_status;
   eng_status_type   eng_status;
   logic             no_work;

   // classify incoming words; drop sets the model ignores into skip words
   mclb_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_channel    (req_channel),
      .req_action     (req_action),
      .req_on_period  (req_on_period),
      .req_off_period (req_off_period),
      .req_paused     (req_paused),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_word         (q_wr_word)
   );

   // hold words while the engine walks
   mclb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_word (q_wr_word),
      .pop     (q_pop),
      .rd_word (q_rd_word),
      .status  (q_status)
   );

   // advance countdowns, drive LEDs and strobe one result per word
   mclb_engine #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_word           (q_rd_word),
      .q_pop            (q_pop),
      .status           (eng_status),
      .rsp_valid        (rsp_valid),
      .rsp_led_levels   (rsp_led_levels),
      .rsp_pattern_show (rsp_pattern_show)
   );

   assign no_work = !start && q_status.empty && eng_status.idle;

   // no work pending means no strobe next cycle
   `MCLB_ASSERT_NEXT(a_no_spurious_rsp, no_work, !rsp_valid, "strobe with no word pending")
   // an idle engine leaves the LED drive alone
   `MCLB_ASSERT_NEXT(a_led_idle, eng_status.idle, $stable(rsp_led_levels), "LED moved in idle")
   // the engine never draws from an empty queue
   `MCLB_ASSERT_SAME(a_no_underflow, eng_status.load, !q_status.empty, "pop from empty queue")

endmodule

`default_nettype wire

// File: hdl/mclb_front.sv
// ----------------------------------------------------------------------------
// Blinker front end
// Accepts request words and classifies them as tick, set or dropped set.
// ----------------------------------------------------------------------------
`default_nettype none

module mclb_front
   import mclb_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_mode,
   input  wire logic [CH_W-1:0]  req_channel,
   input  wire logic [1:0]       req_action,
   input  wire logic [CNT_W-1:0] req_on_period,
   input  wire logic [CNT_W-1:0] req_off_period,
   input  wire logic             req_paused,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output cmd_type               q_word
);

   logic [CH_EXT_W-1:0] ch_ext;
   logic                set_ok;

   assign ch_ext = CH_EXT_W'(req_channel);
   // drop sets to absent channels, and plain channels while paused
   assign set_ok = (ch_ext < CH_EXT_W'(NUM_CHANNELS)) &&
                   !(req_paused && (ch_ext != PATTERN_CH));

   assign busy   = q_status.full;
   assign q_push = start && !q_status.full;

   always_comb begin
      q_word.channel    = req_channel;
      q_word.action     = action_type'(req_action);
      q_word.on_period  = req_on_period;
      q_word.off_period = req_off_period;
      q_word.paused     = req_paused;
      if (!req_mode) begin
         q_word.kind = CMD_TICK;
      end else if (set_ok) begin
         q_word.kind = CMD_SET;
      end else begin
         q_word.kind = CMD_SKIP;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mclb_queue.sv
// ----------------------------------------------------------------------------
// Blinker command queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mclb_queue
   import mclb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    wr_word,
   input  wire logic       pop,
   output cmd_type         rd_word,
   output queue_status_type status
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

   assign rd_word      = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: hdl/mclb_engine.sv
// ----------------------------------------------------------------------------
// Blinker channel engine
// Walks the channels one per cycle, updates countdowns and LED drive.
// ----------------------------------------------------------------------------
`default_nettype none

module mclb_engine
   import mclb_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_status_type q_status,
   input  wire cmd_type      q_word,
   output logic              q_pop,
   output eng_status_type    status,
   output logic              rsp_valid,
   output logic [LED_W-1:0]  rsp_led_levels,
   output logic              rsp_pattern_show
);

   localparam int IW = $clog2(NUM_CHANNELS);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type           state_ff;
   cmd_type             cmd_ff;
   logic [IW-1:0]       idx_ff;
   logic                pulse_acc_ff;
   logic [CNT_W-1:0]    cnt_ff  [NUM_CHANNELS];
   action_type          act_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]    on_ff   [NUM_CHANNELS];
   logic [CNT_W-1:0]    off_ff  [NUM_CHANNELS];
   logic [LED_W-1:0]    led_ff;
   logic                valid_ff;
   logic                show_ff;

   logic                is_tick;
   logic                is_set;
   logic [CH_EXT_W-1:0] ch_ext;
   logic                plain;
   logic                is_pat;
   logic [LED_W-1:0]    mask;
   action_type          cur_act;
   logic [CNT_W-1:0]    cur_on;
   logic [CNT_W-1:0]    cur_off;
   logic [CNT_W-1:0]    dec;
   logic [CNT_W-1:0]    cnt_base;
   logic [LED_W-1:0]    led_base;
   logic [LED_W-1:0]    led_new;
   logic [CNT_W-1:0]    cnt_new;
   logic                pulse_now;
   logic                do_proc;
   logic                halt;
   logic                last;
   logic                walking;
   logic                finish;
   logic                load;
   logic [CNT_W-1:0]    cnt_in;
   logic [LED_W-1:0]    led_in;
   logic                pulse_in;

   assign is_tick = (cmd_ff.kind == CMD_TICK);
   assign is_set  = (cmd_ff.kind == CMD_SET);
   assign ch_ext  = CH_EXT_W'(idx_ff);
   assign plain   = (ch_ext < CH_EXT_W'(LED_W));
   assign is_pat  = (ch_ext == PATTERN_CH);
   assign mask    = plain ? (LED_W'(1) << idx_ff) : '0;

   // a set uses the incoming style, a tick the stored one
   assign cur_act  = is_set ? cmd_ff.action     : act_ff[idx_ff];
   assign cur_on   = is_set ? cmd_ff.on_period  : on_ff[idx_ff];
   assign cur_off  = is_set ? cmd_ff.off_period : off_ff[idx_ff];
   assign dec      = cnt_ff[idx_ff] - CNT_W'(1);
   assign cnt_base = is_set ? cnt_ff[idx_ff] : dec;
   assign led_base = (is_set && (cur_act == ACT_BLINK)) ? (led_ff & ~mask) : led_ff;

   always_comb begin
      led_new   = led_base;
      cnt_new   = cnt_base;
      pulse_now = 1'b0;
      case (cur_act)
         ACT_ON: begin
            led_new   = led_base | mask;
            pulse_now = is_pat;
            cnt_new   = RELOAD_ON;
         end
         ACT_OFF: begin
            led_new = led_base & ~mask;
            cnt_new = RELOAD_OFF;
         end
         ACT_BLINK: begin
            if (plain) begin
               led_new = led_base ^ mask;
               cnt_new = (((led_base ^ mask) & mask) != '0) ? cur_on : cur_off;
            end
         end
         default: begin
         end
      endcase
   end

   assign halt    = is_tick && (dec == '0) && cmd_ff.paused && !is_pat;
   assign do_proc = is_set || (is_tick && (dec == '0) && !halt);
   assign last    = !is_tick || halt || (idx_ff == IW'(NUM_CHANNELS - 1));
   assign walking = (state_ff == S_WALK);
   assign finish  = walking && last;
   assign load    = !q_status.empty && ((state_ff == S_IDLE) || finish);

   assign cnt_in   = do_proc ? cnt_new : cnt_base;
   assign led_in   = do_proc ? led_new : led_ff;
   assign pulse_in = pulse_acc_ff || (do_proc && pulse_now);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         pulse_acc_ff <= 1'b0;
         led_ff       <= '0;
         valid_ff     <= 1'b0;
         show_ff      <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cnt_ff[i] <= RELOAD_RESET;
            act_ff[i] <= ACT_NONE;
            on_ff[i]  <= RELOAD_RESET;
            off_ff[i] <= RELOAD_RESET;
         end
      end else begin
         valid_ff <= finish;
         show_ff  <= finish && pulse_in;
         if (walking) begin
            if (is_tick || is_set) begin
               cnt_ff[idx_ff] <= cnt_in;
               led_ff         <= led_in;
            end
            if (is_set) begin
               act_ff[idx_ff] <= cmd_ff.action;
               on_ff[idx_ff]  <= cmd_ff.on_period;
               off_ff[idx_ff] <= cmd_ff.off_period;
            end
         end
         if (load) begin
            state_ff     <= S_WALK;
            cmd_ff       <= q_word;
            idx_ff       <= (q_word.kind == CMD_SET) ? IW'(q_word.channel) : '0;
            pulse_acc_ff <= 1'b0;
         end else if (finish) begin
            state_ff <= S_IDLE;
         end else if (walking) begin
            idx_ff       <= idx_ff + IW'(1);
            pulse_acc_ff <= pulse_in;
         end
      end
   end

   assign q_pop            = load;
   assign status.idle      = (state_ff == S_IDLE);
   assign status.load      = load;
   assign rsp_valid        = valid_ff;
   assign rsp_led_levels   = led_ff;
   assign rsp_pattern_show = show_ff;

endmodule

`default_nettype wire

// File: tb/multi_channel_led_blinker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel LED blinker checker
// Watches both channels, predicts LED levels and pattern pulses per word and
// compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------

module multi_channel_led_blinker_checker
   import mclb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire logic             req_mode,
   input  wire logic [CH_W-1:0]  req_channel,
   input  wire logic [1:0]       req_action,
   input  wire logic [CNT_W-1:0] req_on_period,
   input  wire logic [CNT_W-1:0] req_off_period,
   input  wire logic             req_paused,
   input  wire logic             rsp_valid,
   input  wire logic [LED_W-1:0] rsp_led_levels,
   input  wire logic             rsp_pattern_show,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int CHANNELS        = 4;
   localparam int LED_CHANNELS    = LED_W;
   localparam int PATTERN_CHANNEL = int'(PATTERN_CH);
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [LED_W-1:0] levels;
      logic             show;
   } led_word_type;

   logic [CNT_W-1:0] countdown [CHANNELS];
   action_type       style     [CHANNELS];
   logic [CNT_W-1:0] on_time   [CHANNELS];
   logic [CNT_W-1:0] off_time  [CHANNELS];
   logic [LED_W-1:0] drive;
   logic             pulse;
   int               errors = 0;
   led_word_type     expected_leds [$];

   task automatic fire_channel(input int ch);
      logic [LED_W-1:0] mask;
      mask = (ch < LED_CHANNELS) ? LED_W'(1 << ch) : '0;
      case (style[ch])
         ACT_ON: begin
            drive = drive | mask;
            if (ch == PATTERN_CHANNEL) pulse = 1'b1;
            countdown[ch] = RELOAD_ON;
         end
         ACT_OFF: begin
            drive = drive & ~mask;
            countdown[ch] = RELOAD_OFF;
         end
         ACT_BLINK: begin
            if (ch < LED_CHANNELS) begin
               drive = drive ^ mask;
               countdown[ch] = ((drive & mask) != '0) ? on_time[ch] : off_time[ch];
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_led_step(input cmd_kind_type kind, input int ch,
                                   input action_type act, input logic [CNT_W-1:0] onp,
                                   input logic [CNT_W-1:0] offp, input logic paused);
      logic halted;
      halted = 1'b0;
      pulse  = 1'b0;
      if (kind == CMD_TICK) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (!halted) begin
               countdown[i] = countdown[i] - CNT_W'(1);
               if (countdown[i] == '0) begin
                  // a paused walk halts at the first plain channel that expires
                  if (paused && i != PATTERN_CHANNEL) halted = 1'b1;
                  else fire_channel(i);
               end
            end
         end
      end else if (!(paused && ch != PATTERN_CHANNEL)) begin
         style[ch]    = act;
         on_time[ch]  = onp;
         off_time[ch] = offp;
         if (act == ACT_BLINK && ch < LED_CHANNELS) drive = drive & ~LED_W'(1 << ch);
         fire_channel(ch);
      end
      expected_leds.push_back('{levels: drive, show: pulse});
   endtask

   always @(posedge clock) begin
      led_word_type want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            countdown[i] = RELOAD_RESET;
            style[i]     = ACT_NONE;
            on_time[i]   = RELOAD_RESET;
            off_time[i]  = RELOAD_RESET;
         end
         drive = '0;
         pulse = 1'b0;
         expected_leds.delete();
      end else begin
         // results first: a word accepted at this edge cannot answer at it
         if (rsp_valid) begin
            if (expected_leds.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected word: led_levels %b pattern_show %b",
                           rsp_led_levels, rsp_pattern_show);
            end else begin
               want = expected_leds.pop_front();
               if (rsp_led_levels !== want.levels || rsp_pattern_show !== want.show) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("mismatch: led_levels exp %b got %b, %s %b got %b",
                              want.levels, rsp_led_levels, "pattern_show exp",
                              want.show, rsp_pattern_show);
               end
            end
         end
         if (start && !busy)
            predict_led_step(req_mode ? CMD_SET : CMD_TICK, int'(req_channel),
                             action_type'(req_action), req_on_period, req_off_period,
                             req_paused);
      end
      fail_count    <= errors;
      pending_count <= expected_leds.size();
   end

endmodule

// File: tb/multi_channel_led_blinker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel LED blinker testbench
// Drives directed and random tick and set-style words with random gaps and
// leaves all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module multi_channel_led_blinker_tb;
   import mclb_pkg::*;

   localparam int RANDOM_WORDS  = 1530;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_mode = 1'b0;
   logic [CH_W-1:0]  req_channel = '0;
   logic [1:0]       req_action = '0;
   logic [CNT_W-1:0] req_on_period = '0;
   logic [CNT_W-1:0] req_off_period = '0;
   logic             req_paused = 1'b0;
   logic             rsp_valid;
   logic [LED_W-1:0] rsp_led_levels;
   logic             rsp_pattern_show;
   int               fail_count;
   int               pending_count;
   int               cycle_count = 0;
   logic             steady_run = 1'b0;

   multi_channel_led_blinker uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_channel      (req_channel),
      .req_action       (req_action),
      .req_on_period    (req_on_period),
      .req_off_period   (req_off_period),
      .req_paused       (req_paused),
      .rsp_valid        (rsp_valid),
      .rsp_led_levels   (rsp_led_levels),
      .rsp_pattern_show (rsp_pattern_show)
   );

   multi_channel_led_blinker_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_channel      (req_channel),
      .req_action       (req_action),
      .req_on_period    (req_on_period),
      .req_off_period   (req_off_period),
      .req_paused       (req_paused),
      .rsp_valid        (rsp_valid),
      .rsp_led_levels   (rsp_led_levels),
      .rsp_pattern_show (rsp_pattern_show),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // 20 ns period: high half, then low half
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: abandon a hung run long after the slowest honest one would end
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Gap after a word: mostly none, sometimes a short pause, now and then a long
   // lull. During a steady run hold start high back to back.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_run) return 0;
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Blink periods stay small most of the time so that channels keep expiring;
   // a share of full-range values exercises every bit of the period fields.
   function automatic logic [CNT_W-1:0] pick_period();
      if ($urandom_range(0, 99) < 80) return CNT_W'($urandom_range(0, 12));
      return CNT_W'($urandom);
   endfunction

   // Present one word and hold it until the block takes it (start high, busy
   // low at an edge), then idle for the requested gap. Start is only lowered
   // when a gap follows, so back-to-back words keep it high throughout.
   task automatic send_word(input cmd_kind_type kind, input logic [CH_W-1:0] ch,
                            input action_type act, input logic [CNT_W-1:0] onp,
                            input logic [CNT_W-1:0] offp, input logic paused,
                            input int gap);
      req_mode       <= (kind == CMD_SET);
      req_channel    <= ch;
      req_action     <= act;
      req_on_period  <= onp;
      req_off_period <= offp;
      req_paused     <= paused;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and hold off until every predicted word has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // One random word: ticks dominate so countdowns run down; sets mostly aim at
   // blink with short periods to keep LEDs toggling, and a few paused words
   // freeze the walk or drop plain-channel sets.
   task automatic send_random_word();
      int               roll;
      logic             paused;
      logic [CH_W-1:0]  ch;
      action_type       act;
      roll   = $urandom_range(0, 99);
      paused = ($urandom_range(0, 99) < 12);
      ch     = CH_W'($urandom_range(0, 3));
      if (roll < 65) begin
         // the set fields carry noise on a tick and must be ignored
         send_word(CMD_TICK, ch, action_type'($urandom_range(0, 3)), CNT_W'($urandom),
                   CNT_W'($urandom), paused, pick_gap());
      end else begin
         act = ($urandom_range(0, 99) < 45) ? ACT_BLINK : action_type'($urandom_range(0, 3));
         send_word(CMD_SET, ch, act, pick_period(), pick_period(), paused, pick_gap());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: a tick with every set field at its top value
      send_word(CMD_TICK, 2'd3, ACT_BLINK, 16'hFFFF, 16'hFFFF, 1'b0, 0);
      // on and off on plain channels, periods at both extremes
      send_word(CMD_SET, 2'd0, ACT_ON,    16'hFFFF, 16'h0000, 1'b0, 0);
      send_word(CMD_SET, 2'd1, ACT_OFF,   16'h0000, 16'hFFFF, 1'b0, 1);
      // blink with a zero on period: LED forced low, turned on, countdown wraps
      send_word(CMD_SET, 2'd2, ACT_BLINK, 16'h0000, 16'hFFFF, 1'b0, 0);
      // pattern channel: on pulses, blink does nothing, then off and none
      send_word(CMD_SET, 2'd3, ACT_ON,    16'h0005, 16'h0007, 1'b0, 0);
      send_word(CMD_SET, 2'd3, ACT_BLINK, 16'h0001, 16'h0001, 1'b0, 2);
      send_word(CMD_SET, 2'd3, ACT_OFF,   16'h0002, 16'h0003, 1'b0, 0);
      send_word(CMD_SET, 2'd3, ACT_NONE,  16'h0004, 16'h0004, 1'b0, 0);
      send_word(CMD_SET, 2'd0, ACT_NONE,  16'h0003, 16'h0003, 1'b0, 0);
      // paused set: dropped on a plain channel, honoured on the pattern channel
      send_word(CMD_SET, 2'd1, ACT_ON,    16'h0001, 16'h0001, 1'b1, 0);
      send_word(CMD_SET, 2'd3, ACT_ON,    16'h0001, 16'h0001, 1'b1, 3);
      // paused tick that halts at an expiring plain channel, then a wrap
      send_word(CMD_SET, 2'd0, ACT_BLINK, 16'h0001, 16'h0002, 1'b0, 0);
      send_word(CMD_TICK, 2'd0, ACT_NONE, 16'h0000, 16'h0000, 1'b1, 0);
      send_word(CMD_TICK, 2'd0, ACT_NONE, 16'h0000, 16'h0000, 1'b0, 0);
      // short blink periods toggling across several ticks
      send_word(CMD_SET, 2'd0, ACT_BLINK, 16'h0001, 16'h0001, 1'b0, 0);
      send_word(CMD_SET, 2'd1, ACT_BLINK, 16'h0002, 16'h0003, 1'b0, 0);
      repeat (6) send_word(CMD_TICK, 2'd2, ACT_OFF, 16'h0000, 16'h0000, 1'b0, 0);
      drain_results();

      // Random part, with two full drains partway through
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 128 == 0) steady_run = ($urandom_range(0, 3) == 0);
         if (n == 500 || n == 1100) drain_results();
         send_random_word();
      end

      // Wait for the tail of results, then allow stray strobes to show up
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/mclb_pkg.sv
hdl/mclb_front.sv
hdl/mclb_queue.sv
hdl/mclb_engine.sv
hdl/multi_channel_led_blinker.sv
tb/multi_channel_led_blinker_checker.sv
tb/multi_channel_led_blinker_tb.sv
